// ----- design/pbc_pkg.sv -----
// Shared types, constants and helpers for the pixel brightness and contrast block.
package pbc_pkg;

	// Sample and configuration widths.
	localparam int ChanW = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	// Widths of the derived coefficients.
	localparam int BoffW = 18;
	localparam int GainW = 12;
	localparam int CoffW = 28;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_WIDE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_YUV = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BRIGHT = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CONTRAST = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LUMA = 3'd4;

	// Reciprocals for exact truncating division by 100 and by 25.
	localparam logic [23:0] Recip100 = 24'd10737419;
	localparam logic [17:0] Recip25 = 18'd167773;

	// Identity gain (1.0 in signed 4.8 fixed point).
	localparam logic signed [GainW-1:0] GainUnity = 12'sd256;

	typedef logic [ChanW-1:0] chan_t;

	// Coefficients derived from the configuration registers.
	typedef struct packed {
		logic signed [BoffW-1:0] boff;
		logic signed [GainW-1:0] gain;
		logic signed [CoffW-1:0] coff;
	} coef_t;

	// Full-scale sample value for the selected sample width.
	function automatic chan_t max_of(input logic wide);
		max_of = wide ? 16'hFFFF : 16'h00FF;
	endfunction

endpackage

// ----- design/pbc_coef.sv -----
// Derives brightness offset, contrast gain and contrast offset from configuration.
module pbc_coef (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wide,
	input  logic signed [pbc_pkg::CfgDataW-1:0]  bright,
	input  logic signed [pbc_pkg::CfgDataW-1:0]  contrast,
	output pbc_pkg::coef_t                       coef
);

	logic [7:0]                           bmag;
	logic [23:0]                          bscaled;
	logic [47:0]                          bprod;
	logic [17:0]                          bquot;
	logic signed [pbc_pkg::BoffW-1:0]     boff_d;
	logic signed [pbc_pkg::BoffW-1:0]     boff_q;
	logic signed [8:0]                    cterm;
	logic [7:0]                           cmag;
	logic [15:0]                          cnum;
	logic [33:0]                          cprod;
	logic [11:0]                          gquot;
	logic signed [pbc_pkg::GainW-1:0]     gain_d;
	logic signed [pbc_pkg::GainW-1:0]     gain_q;
	logic signed [28:0]                   gext;
	logic signed [28:0]                   gscaled;
	logic signed [28:0]                   gadj;
	logic signed [28:0]                   ghalf;
	logic signed [pbc_pkg::CoffW-1:0]     coff_d;
	logic signed [pbc_pkg::CoffW-1:0]     coff_q;
	pbc_pkg::chan_t                       maxv;

	assign maxv = pbc_pkg::max_of(wide);

	// Brightness offset: |b| * max / 100, truncated toward zero, sign restored.
	always_comb begin
		bmag = bright[7] ? 8'(-bright) : 8'(bright);
		if (wide) begin
			bscaled = {bmag, 16'h0} - {16'h0, bmag};
		end else begin
			bscaled = {8'h0, bmag, 8'h0} - {16'h0, bmag};
		end
		bprod = bscaled * pbc_pkg::Recip100;
		bquot = bprod[47:30];
		boff_d = bright[7] ? 18'(-bquot) : 18'(bquot);
	end

	// Contrast gain: (c+100)*64/25 below zero, (c+25)*256/25 otherwise.
	always_comb begin
		if (contrast[7]) begin
			cterm = 9'(contrast) + 9'sd100;
		end else begin
			cterm = 9'(contrast) + 9'sd25;
		end
		cmag = cterm[8] ? 8'(-cterm) : 8'(cterm);
		cnum = contrast[7] ? {2'b00, cmag, 6'h0} : {cmag, 8'h0};
		cprod = cnum * pbc_pkg::Recip25;
		gquot = cprod[33:22];
		gain_d = cterm[8] ? 12'(-gquot) : 12'(gquot);
	end

	// Contrast offset: max*128 - trunc(max*gain/2), from the registered gain.
	always_comb begin
		gext = 29'(gain_q);
		if (wide) begin
			gscaled = (gext <<< 16) - gext;
		end else begin
			gscaled = (gext <<< 8) - gext;
		end
		gadj = gscaled + $signed(29'(gscaled[28] & gscaled[0]));
		ghalf = gadj >>> 1;
		coff_d = $signed({5'b0, maxv, 7'b0}) - 28'(ghalf);
	end

	// Coefficient registers; reset holds the identity setting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boff_q <= '0;
			gain_q <= pbc_pkg::GainUnity;
			coff_q <= '0;
		end else begin
			boff_q <= boff_d;
			gain_q <= gain_d;
			coff_q <= coff_d;
		end
	end

	assign coef.boff = boff_q;
	assign coef.gain = gain_q;
	assign coef.coff = coff_q;

endmodule

// ----- design/pbc_bright.sv -----
// Adds the brightness offset to one channel and clamps to the sample range.
module pbc_bright (
	input  pbc_pkg::chan_t                   x,
	input  logic signed [pbc_pkg::BoffW-1:0] boff,
	input  logic                             wide,
	output pbc_pkg::chan_t                   y
);

	logic signed [18:0] sum;
	pbc_pkg::chan_t     maxv;

	assign maxv = pbc_pkg::max_of(wide);

	// Offset add, then clamp to 0..max.
	always_comb begin
		sum = $signed({3'b000, x}) + 19'(boff);
		if (sum[18]) begin
			y = '0;
		end else if (sum[17:0] > {2'b00, maxv}) begin
			y = maxv;
		end else begin
			y = sum[15:0];
		end
	end

endmodule

// ----- design/pbc_scale.sv -----
// Applies contrast gain and offset to one channel and clamps to the sample range.
module pbc_scale (
	input  pbc_pkg::chan_t                   x,
	input  logic signed [pbc_pkg::GainW-1:0] gain,
	input  logic signed [pbc_pkg::CoffW-1:0] coff,
	input  logic                             wide,
	output pbc_pkg::chan_t                   y
);

	logic signed [28:0] prod;
	logic signed [29:0] acc;
	pbc_pkg::chan_t     maxv;

	assign maxv = pbc_pkg::max_of(wide);

	// x*gain + offset, divide by 256, clamp to 0..max.
	always_comb begin
		prod = $signed({1'b0, x}) * gain;
		acc = 30'(prod) + 30'(coff);
		if (acc[29]) begin
			y = '0;
		end else if (acc[29:8] > {6'h0, maxv}) begin
			y = maxv;
		end else begin
			y = acc[23:8];
		end
	end

endmodule

// ----- design/pixel_brightness_contrast.sv -----
// Top level of the pixel brightness and contrast block.
// A result passes the input, brightness and contrast stage registers before output.
// Throughput: one pixel per cycle; three register stages, stalled only by out_ready.
// A configuration write passes the configuration, then the coefficient registers.
// Reset (arst_n low) clears all valid flags and restores the register defaults.
module pixel_brightness_contrast (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pbc_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [pbc_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      chan_zero,
	input  logic [15:0]                      chan_one,
	input  logic [15:0]                      chan_two,
	input  logic [15:0]                      alpha_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      out_zero,
	output logic [15:0]                      out_one,
	output logic [15:0]                      out_two,
	output logic [15:0]                      alpha_out
);

	logic                                   wide_q;
	logic                                   yuv_q;
	logic signed [pbc_pkg::CfgDataW-1:0]    bright_q;
	logic signed [pbc_pkg::CfgDataW-1:0]    contrast_q;
	logic                                   luma_q;
	pbc_pkg::coef_t                         coef;
	pbc_pkg::chan_t                         maxv;

	logic                                   v_s1;
	logic                                   v_s2;
	logic                                   v_s3;
	logic                                   free_s1;
	logic                                   free_s2;
	logic                                   free_s3;

	pbc_pkg::chan_t                         c0_s1, c1_s1, c2_s1, al_s1;
	pbc_pkg::chan_t                         c0_s2, c1_s2, c2_s2, al_s2;
	pbc_pkg::chan_t                         c0_s3, c1_s3, c2_s3, al_s3;
	pbc_pkg::chan_t                         b0, b1, b2;
	pbc_pkg::chan_t                         k0, k1, k2;

	assign maxv = pbc_pkg::max_of(wide_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b0;
			yuv_q <= 1'b0;
			bright_q <= '0;
			contrast_q <= '0;
			luma_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pbc_pkg::REG_WIDE:     wide_q <= cfg_data[0];
				pbc_pkg::REG_YUV:      yuv_q <= cfg_data[0];
				pbc_pkg::REG_BRIGHT:   bright_q <= cfg_data;
				pbc_pkg::REG_CONTRAST: contrast_q <= cfg_data;
				pbc_pkg::REG_LUMA:     luma_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pbc_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.wide     (wide_q),
		.bright   (bright_q),
		.contrast (contrast_q),
		.coef     (coef)
	);

	// Stage flow control: a stage takes new data when empty or draining.
	assign free_s3 = !v_s3 || out_ready;
	assign free_s2 = !v_s2 || free_s3;
	assign free_s1 = !v_s1 || free_s2;
	assign in_ready = free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1 <= in_valid;
			end
			if (free_s2) begin
				v_s2 <= v_s1;
			end
			if (free_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Input stage: samples reduced to the active sample width.
	always_ff @(posedge clk) begin
		if (in_valid && free_s1) begin
			c0_s1 <= chan_zero & maxv;
			c1_s1 <= chan_one & maxv;
			c2_s1 <= chan_two & maxv;
			al_s1 <= alpha_in & maxv;
		end
	end

	// Brightness stage: chroma bypasses the offset in YUV formats.
	pbc_bright u_bright0 (.x(c0_s1), .boff(coef.boff), .wide(wide_q), .y(b0));
	pbc_bright u_bright1 (.x(c1_s1), .boff(coef.boff), .wide(wide_q), .y(b1));
	pbc_bright u_bright2 (.x(c2_s1), .boff(coef.boff), .wide(wide_q), .y(b2));

	always_ff @(posedge clk) begin
		if (v_s1 && free_s2) begin
			c0_s2 <= b0;
			c1_s2 <= yuv_q ? c1_s1 : b1;
			c2_s2 <= yuv_q ? c2_s1 : b2;
			al_s2 <= al_s1;
		end
	end

	// Contrast stage: chroma passes when luma-only applies to a YUV format.
	pbc_scale u_scale0 (
		.x(c0_s2), .gain(coef.gain), .coff(coef.coff), .wide(wide_q), .y(k0)
	);
	pbc_scale u_scale1 (
		.x(c1_s2), .gain(coef.gain), .coff(coef.coff), .wide(wide_q), .y(k1)
	);
	pbc_scale u_scale2 (
		.x(c2_s2), .gain(coef.gain), .coff(coef.coff), .wide(wide_q), .y(k2)
	);

	always_ff @(posedge clk) begin
		if (v_s2 && free_s3) begin
			c0_s3 <= k0;
			c1_s3 <= (yuv_q && luma_q) ? c1_s2 : k1;
			c2_s3 <= (yuv_q && luma_q) ? c2_s2 : k2;
			al_s3 <= al_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_zero = c0_s3;
	assign out_one = c1_s3;
	assign out_two = c2_s3;
	assign alpha_out = al_s3;

`ifndef SYNTHESIS
	// In 8-bit mode no result exceeds the 8-bit full scale.
	a_narrow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wide_q |-> out_zero[15:8] == 8'h00 && out_one[15:8] == 8'h00
			&& out_two[15:8] == 8'h00 && alpha_out[15:8] == 8'h00)
		else $error("result exceeds 8-bit full scale");

	// A full, stalled pipeline must refuse new requests.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && !out_ready |-> !in_ready)
		else $error("request accepted while pipeline is full");

	// A settled zero contrast must give the identity gain.
	a_unity_gain: assert property (@(posedge clk) disable iff (!arst_n)
		contrast_q == 8'sd0 && $stable(contrast_q) |-> coef.gain == pbc_pkg::GainUnity)
		else $error("zero contrast does not give unity gain");
`endif

endmodule
